// ===== src/olti_pkg.sv =====
package olti_pkg;

	// Built table depth and derived index widths
	localparam int DEPTH    = 1024;
	localparam int IDX_W    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int RD_IDX_W = (IDX_W < 2) ? 2 : IDX_W;
	localparam int GRP_BITS = RD_IDX_W / 2;
	localparam int HI_BITS  = RD_IDX_W - GRP_BITS;
	localparam int GRP      = 2 ** GRP_BITS;
	localparam int NGRP     = 2 ** HI_BITS;
	localparam int PAD_N    = NGRP * GRP;

	// Field widths fixed by the interface
	localparam int CNT_W  = 11;
	localparam int BYTE_W = 8;

	// Depth as a count value; saturates when the depth outgrows the count field
	localparam logic [CNT_W-1:0] DEPTH_CLAMP =
		(DEPTH < 2 ** CNT_W) ? CNT_W'(DEPTH) : {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_POS = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] hop;
		logic [BYTE_W-1:0] prefix;
	} entry_t;

	// Per-cell shift controls
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// Chain-wide insert step controls
	typedef struct packed {
		logic             step;
		logic [IDX_W-1:0] pos;
	} chain_ctrl_t;

endpackage

// ===== src/olti_cell.sv =====
module olti_cell
	import olti_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     left,
	input  entry_t     fresh,
	output entry_t     entry_q
);

	// Load the new entry at the insertion point, otherwise take the left neighbor
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= fresh;
		end else if (ctrl.shift) begin
			entry_q <= left;
		end
	end

endmodule

// ===== src/olti_chain.sv =====
module olti_chain
	import olti_pkg::*;
(
	input  logic                clk,
	input  chain_ctrl_t         ctrl,
	input  entry_t              fresh,
	input  logic [RD_IDX_W-1:0] rd_pos,
	output entry_t              rd_entry_s2
);

	entry_t                     cell_q [PAD_N];
	entry_t                     grp_d  [NGRP];
	entry_t                     grp_s1 [NGRP];
	logic   [HI_BITS-1:0]       hi_s1;
	logic   [GRP_BITS-1:0]      lo;

	// Row of cells; slots past the built depth read as zero
	for (genvar k = 0; k < PAD_N; k++) begin : g_cell
		if (k < DEPTH) begin : g_real
			cell_ctrl_t cc;
			entry_t     left;
			assign cc.load  = ctrl.step && (ctrl.pos == IDX_W'(k));
			assign cc.shift = ctrl.step && (ctrl.pos < IDX_W'(k));
			if (k == 0) begin : g_first
				assign left = fresh;
			end else begin : g_next
				assign left = cell_q[k-1];
			end
			olti_cell u_cell (
				.clk     (clk),
				.ctrl    (cc),
				.left    (left),
				.fresh   (fresh),
				.entry_q (cell_q[k])
			);
		end else begin : g_pad
			assign cell_q[k] = '0;
		end
	end

	assign lo = rd_pos[GRP_BITS-1:0];

	// Read stage 1: pick one entry inside every group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = cell_q[{HI_BITS'(g), lo}];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
		hi_s1  <= rd_pos[RD_IDX_W-1:GRP_BITS];
	end

	// Read stage 2: pick the group
	always_ff @(posedge clk) begin
		rd_entry_s2 <= grp_s1[hi_s1];
	end

endmodule

// ===== src/ordered_leaf_table_insert.sv =====
// Ordered leaf table with run insertion.
// Input channel (in_valid/in_ready): op, position, run_length, hop_value,
// prefix_length. An insert places run_length copies of an entry at position
// and moves the later entries right; a read returns the entry at position.
// Output channel (out_valid/out_ready): one beat per input beat with status,
// read_hop, read_prefix and fill_count, in input order.
// Config channel (cfg_valid/cfg_data): capacity, always ready; write it only
// while the block is idle.
// Sequence: an insert with a nonzero run that passes its checks stays in
// S_SHIFT until the run is placed, since the row of cells moves every entry
// one place per cycle, then goes to S_DONE. Rejected or empty inserts go
// straight to S_DONE; reads pass S_RD1 and S_RD2 (two-stage registered select
// over the cells) to S_DONE. One item is in flight at a time; once the result
// is loaded into the output register the block is ready again on the next
// cycle, while that beat may still wait. Reset clears the fill count and sets
// capacity to 1024; entry contents are left as they are. A stalled receiver
// holds the result in the output register; the next result waits in S_DONE
// until the beat is taken.
module ordered_leaf_table_insert
	import olti_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [CNT_W-1:0]  position,
	input  logic [CNT_W-1:0]  run_length,
	input  logic [BYTE_W-1:0] hop_value,
	input  logic [BYTE_W-1:0] prefix_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] read_hop,
	output logic [BYTE_W-1:0] read_prefix,
	output logic [CNT_W-1:0]  fill_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SHIFT = 5'b00010,
		S_RD1   = 5'b00100,
		S_RD2   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [CNT_W-1:0]  run_left_q;
	logic [CNT_W-1:0]  pos_q;
	entry_t            fresh_q;
	status_t           status_q;
	logic              rd_ok_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	entry_t            out_entry_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W:0]    cnt_plus_run;
	logic [CNT_W:0]    pos_plus_run;
	logic              chk_full;
	logic              chk_pos;
	status_t           ins_status;
	logic              rd_hit;
	logic              in_fire;
	logic              out_load;
	chain_ctrl_t       chain_ctrl;
	entry_t            rd_entry_s2;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// Insert and read checks, in priority order
	assign cap_eff      = (capacity_q > DEPTH_CLAMP) ? DEPTH_CLAMP : capacity_q;
	assign cnt_plus_run = {1'b0, entry_count_q} + {1'b0, run_length};
	assign pos_plus_run = {1'b0, position} + {1'b0, run_length};
	assign chk_full     = cnt_plus_run > {1'b0, cap_eff};
	assign chk_pos      = (pos_plus_run > {1'b0, cap_eff}) || (position > entry_count_q);
	assign ins_status   = chk_full ? ST_FULL : (chk_pos ? ST_BAD_POS : ST_OK);
	assign rd_hit       = position < entry_count_q;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			run_left_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (op == OP_READ) begin
							state_q <= S_RD1;
						end else if (ins_status == ST_OK && run_length != '0) begin
							state_q       <= S_SHIFT;
							run_left_q    <= run_length;
							entry_count_q <= cnt_plus_run[CNT_W-1:0];
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					run_left_q <= run_left_q - CNT_W'(1);
					if (run_left_q == CNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload captured at accept
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_q          <= position;
			fresh_q.hop    <= hop_value;
			fresh_q.prefix <= prefix_length;
			rd_ok_q        <= (op == OP_READ) && rd_hit;
			if (op == OP_READ) begin
				status_q <= rd_hit ? ST_OK : ST_BAD_POS;
			end else begin
				status_q <= ins_status;
			end
		end
	end

	// Cell row with its read select
	assign chain_ctrl.step = (state_q == S_SHIFT);
	assign chain_ctrl.pos  = IDX_W'(pos_q);

	olti_chain u_chain (
		.clk         (clk),
		.ctrl        (chain_ctrl),
		.fresh       (fresh_q),
		.rd_pos      (RD_IDX_W'(pos_q)),
		.rd_entry_s2 (rd_entry_s2)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_entry_q  <= rd_ok_q ? rd_entry_s2 : '0;
			out_count_q  <= entry_count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign read_hop    = out_entry_q.hop;
	assign read_prefix = out_entry_q.prefix;
	assign fill_count  = out_count_q;

	// Fill count never passes the built depth
	a_count_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= DEPTH_CLAMP)
		else $error("fill count beyond depth");

	// Shifting always has steps left
	a_shift_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (run_left_q != '0))
		else $error("shift with no steps left");

	// An accepted nonempty insert that passes its checks starts shifting
	a_insert_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_INSERT && ins_status == ST_OK && run_length != '0)
		|=> (state_q == S_SHIFT))
		else $error("accepted insert did not shift");

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten");

	// Read results come only from in-range positions
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && rd_ok_q) |-> (pos_q < entry_count_q))
		else $error("read past fill count");

endmodule

// ===== tb/sv/ordered_leaf_table_insert_test.sv =====
`timescale 1ns / 100ps

module ordered_leaf_table_insert_test
	import olti_pkg::*;
();

	localparam int IDLE_LIMIT = 4000;	// cycles with no beat on any channel
	localparam int LONG_HOLD  = 300;	// one long receiver stall
	localparam int RAND_ITEMS = 150;	// per capacity phase

	typedef struct packed {
		logic              op;
		logic [CNT_W-1:0]  position;
		logic [CNT_W-1:0]  run;
		logic [BYTE_W-1:0] hop;
		logic [BYTE_W-1:0] prefix;
	} leaf_req_t;

	typedef struct {
		status_t           status;
		logic [BYTE_W-1:0] hop;
		logic [BYTE_W-1:0] prefix;
		logic [CNT_W-1:0]  count;
	} leaf_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic              in_ready;
	leaf_req_t         offer = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status;
	logic [BYTE_W-1:0] read_hop;
	logic [BYTE_W-1:0] read_prefix;
	logic [CNT_W-1:0]  fill_count;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;

	// Shadow of the table: entries, fill count and capacity register
	logic [BYTE_W-1:0] hop_tbl [DEPTH];
	logic [BYTE_W-1:0] pfx_tbl [DEPTH];
	int                tbl_count = 0;
	logic [CNT_W-1:0]  cap_reg = CAP_RESET;

	leaf_req_t    pend_q[$];
	leaf_result_t leaf_result_q[$];

	int n_queued = 0;
	int n_accepted = 0;
	int n_cfg = 0;
	int n_bad = 0;
	int n_placed = 0;
	int n_hits = 0;
	int n_full = 0;
	int n_badpos = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_req = 0;
	int hold_done = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	ordered_leaf_table_insert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (offer.op),
		.position     (offer.position),
		.run_length   (offer.run),
		.hop_value    (offer.hop),
		.prefix_length(offer.prefix),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_hop     (read_hop),
		.read_prefix  (read_prefix),
		.fill_count   (fill_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Apply one request to the shadow table and return the expected beat
	function automatic leaf_result_t apply_leaf_req(input leaf_req_t r);
		leaf_result_t res;
		int cap, pos, run, i;
		cap = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		pos = int'(r.position);
		run = int'(r.run);
		res.status = ST_OK;
		res.hop = '0;
		res.prefix = '0;
		if (r.op == OP_INSERT) begin
			if (tbl_count + run > cap) begin
				res.status = ST_FULL;
			end else if (pos + run > cap || pos > tbl_count) begin
				res.status = ST_BAD_POS;
			end else if (run != 0) begin
				// open a gap of run entries, then fill it
				for (i = tbl_count - 1; i >= pos; i--) begin
					hop_tbl[i + run] = hop_tbl[i];
					pfx_tbl[i + run] = pfx_tbl[i];
				end
				for (i = pos; i < pos + run; i++) begin
					hop_tbl[i] = r.hop;
					pfx_tbl[i] = r.prefix;
				end
				tbl_count += run;
			end
		end else if (pos < tbl_count) begin
			res.hop = hop_tbl[pos];
			res.prefix = pfx_tbl[pos];
		end else begin
			res.status = ST_BAD_POS;
		end
		res.count = CNT_W'(tbl_count);
		return res;
	endfunction

	// Request driver; placed runs and read hits are tallied at accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				leaf_result_q.push_back(apply_leaf_req(offer));
				n_accepted++;
				if (offer.op == OP_INSERT && offer.run != '0 &&
						leaf_result_q[$].status == ST_OK)
					n_placed++;
				else if (offer.op == OP_READ && leaf_result_q[$].status == ST_OK)
					n_hits++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					offer <= pend_q.pop_front();
					in_valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin : take_result
				leaf_result_t want;
				if (leaf_result_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: status %0d fill %0d",
						$time, status, fill_count);
					n_bad++;
				end else begin
					want = leaf_result_q.pop_front();
					case (want.status)
						ST_FULL:    n_full++;
						ST_BAD_POS: n_badpos++;
						default:    ;
					endcase
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						n_bad++;
					end
					if (read_hop !== want.hop) begin
						$display("%0t: read_hop expected %0d actual %0d",
							$time, want.hop, read_hop);
						n_bad++;
					end
					if (read_prefix !== want.prefix) begin
						$display("%0t: read_prefix expected %0d actual %0d",
							$time, want.prefix, read_prefix);
						n_bad++;
					end
					if (fill_count !== want.count) begin
						$display("%0t: fill_count expected %0d actual %0d",
							$time, want.count, fill_count);
						n_bad++;
					end
				end
			end
			if (hold_req != hold_done) begin
				hold_done <= hold_done + 1;
				stall_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: no beat on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic queue_item(input logic op_v, input int pos, input int run,
			input int hop, input int pfx);
		leaf_req_t r;
		r.op = op_v;
		r.position = CNT_W'(pos);
		r.run = CNT_W'(run);
		r.hop = BYTE_W'(hop);
		r.prefix = BYTE_W'(pfx);
		pend_q.push_back(r);
		n_queued++;
	endtask

	// Wait until every queued request has been taken and answered
	task automatic wait_drained();
		while (n_accepted != n_queued || leaf_result_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap_reg = v;
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	// Random request shaped around the current fill and capacity
	task automatic queue_random_item();
		int cnt, cap, room, sel, pos, run, pfx;
		cnt = tbl_count;
		cap = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		room = (cap > cnt) ? cap - cnt : 0;
		sel = $urandom_range(0, 99);
		pfx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 128);
		if (sel < 35) begin
			if (cnt > 0 && $urandom_range(0, 9) < 8)
				pos = $urandom_range(0, cnt - 1);
			else if ($urandom_range(0, 1) == 0)
				pos = cnt;
			else
				pos = $urandom_range(0, 2047);
			queue_item(OP_READ, pos, $urandom_range(0, 2047), $urandom_range(0, 255), pfx);
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				run = $urandom_range(0, 4);
			else if (sel < 70)
				run = $urandom_range(5, 40);
			else if (sel < 73)
				run = room;
			else if (sel < 80)
				run = room + 1;
			else
				run = $urandom_range(0, 2047);
			sel = $urandom_range(0, 99);
			if (sel < 75)
				pos = $urandom_range(0, cnt);
			else if (sel < 85)
				pos = cnt;
			else if (sel < 92)
				pos = cnt + 1;
			else
				pos = $urandom_range(0, 2047);
			queue_item(OP_INSERT, pos, run, $urandom_range(0, 255), pfx);
		end
	endtask

	initial begin
		int ph, k;
		logic [CNT_W-1:0] cap_val;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero capacity: nothing fits, empty run at zero passes
		write_capacity('0);
		queue_item(OP_INSERT, 0, 1, 8'h11, 8);
		queue_item(OP_INSERT, 0, 0, 8'h22, 16);
		queue_item(OP_READ, 0, 0, 0, 0);
		wait_drained();

		// Capacity above depth, clamped: build a few entries and probe edges
		write_capacity({CNT_W{1'b1}});
		queue_item(OP_INSERT, 0, 3, 8'hFF, 128);
		queue_item(OP_INSERT, 0, 2, 8'h00, 0);
		queue_item(OP_INSERT, 5, 1, 8'hA5, 255);
		queue_item(OP_INSERT, 2, 1, 8'h5A, 32);
		queue_item(OP_INSERT, 8, 1, 8'h33, 24);		// beyond the fill count
		queue_item(OP_INSERT, 2047, 2047, 8'hFF, 255);	// overflows
		queue_item(OP_INSERT, 0, 1024, 8'h44, 64);	// overflows by the fill
		queue_item(OP_INSERT, 1024, 0, 8'h55, 1);	// empty run, position too far
		queue_item(OP_INSERT, 7, 0, 8'h66, 2);		// empty run at the end
		queue_item(OP_READ, 0, 0, 0, 0);
		queue_item(OP_READ, 6, 0, 0, 0);
		queue_item(OP_READ, 7, 0, 0, 0);
		queue_item(OP_READ, 2047, 2047, 255, 255);
		queue_item(OP_READ, 3, 0, 0, 0);
		wait_drained();

		// Small capacity: run past the end, then an exact fill
		write_capacity(CNT_W'(10));
		queue_item(OP_INSERT, 8, 3, 8'h77, 12);
		queue_item(OP_INSERT, 7, 3, 8'h88, 20);
		queue_item(OP_INSERT, 0, 1, 8'h99, 30);
		wait_drained();

		// Capacity below the fill count: inserts rejected, reads still served
		write_capacity(CNT_W'(5));
		queue_item(OP_INSERT, 3, 0, 8'hAA, 40);
		queue_item(OP_READ, 9, 0, 0, 0);
		queue_item(OP_READ, 4, 0, 0, 0);
		wait_drained();

		// Random phases, each under its own capacity
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cap_val = CNT_W'(300);
				1: cap_val = CNT_W'(700);
				2: cap_val = CNT_W'($urandom_range(0, 2047));
				3: cap_val = CNT_W'(1024);
				4: cap_val = {CNT_W{1'b1}};
				default: cap_val = CNT_W'(1536);
			endcase
			quiet = (ph == 3);
			write_capacity(cap_val);
			for (k = 0; k < RAND_ITEMS; k++) begin
				while (pend_q.size() != 0)
					@(posedge clk);
				if (ph == 0 && k == 40)
					hold_req++;
				queue_random_item();
			end
			wait_drained();
		end
		quiet = 1'b0;

		repeat (8) @(posedge clk);
		$display("covered %0d requests over %0d capacity settings; final fill %0d",
			n_accepted, n_cfg, tbl_count);
		$display("%0d runs placed, %0d reads served, %0d rejected as full, %0d bad position",
			n_placed, n_hits, n_full, n_badpos);
		if (n_bad == 0 && leaf_result_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
